>>> rtl/core/cbpa_pkg.sv
// Shared types and constants for the contended bus and port access block.
// Used by cbpa_ctrl, cbpa_datapath and the top level; no dependencies.
package cbpa_pkg;

   // Access kinds carried in the request tuser field
   typedef enum logic [1:0] {
      KIND_MEM_RD   = 2'd0,
      KIND_MEM_WR   = 2'd1,
      KIND_PORT_IN  = 2'd2,
      KIND_PORT_OUT = 2'd3
   } kind_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_KEY_ROWS  = 2'd0,
      CSR_JOYSTICK  = 2'd1,
      CSR_ROM_WRITE = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int TSTATE_W = 17;
   // internal time is one bit wider so intermediate sums never wrap
   localparam int TIME_W   = TSTATE_W + 1;

   localparam logic [TSTATE_W-1:0] TSTATE_MAX   = {TSTATE_W{1'b1}};
   localparam logic [ADDR_W-1:0]   ROM_TOP      = 16'h4000;
   localparam logic [1:0]          CONT_BANK    = 2'b01;
   localparam logic [7:0]          JOY_PORT     = 8'h1f;
   localparam logic [7:0]          IDLE_BUS     = 8'hff;
   localparam logic [7:0]          PATTERN_SPAN = 8'd128;
   localparam logic [3:0]          LEN_MEM      = 4'd3;
   localparam logic [3:0]          LEN_IO_EVEN  = 4'd3;
   localparam logic [3:0]          LEN_IO_SHORT = 4'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic       accept;     // latch the request item
      logic       mul;        // first half of a timing step
      logic       add;        // second half: advance time
      logic       mem_access; // RAM read or write this cycle
      logic       load_rsp;   // capture the result item
      logic [1:0] step_idx;   // which timing step is running
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_step;
   } status_type;

   // Contention delay by position within an eight t-state group
   function automatic logic [2:0] delay_of(input logic [2:0] pos);
      logic [2:0] d;
      unique case (pos)
         3'd0:    d = 3'd6;
         3'd1:    d = 3'd5;
         3'd2:    d = 3'd4;
         3'd3:    d = 3'd3;
         3'd4:    d = 3'd2;
         3'd5:    d = 3'd1;
         default: d = 3'd0;
      endcase
      return d;
   endfunction

endpackage

>>> rtl/core/cbpa_ctrl.sv
// Sequencer for the contended bus and port access block.
// Depends on cbpa_pkg; drives cbpa_datapath through cmd_type.
module cbpa_ctrl
   import cbpa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_DONE
   } state_type;

   state_type  state_ff;
   logic [1:0] step_ff;
   logic       rsp_valid_ff;
   logic       slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Commands decoded from state
   always_comb begin
      cmd            = '0;
      cmd.step_idx   = step_ff;
      cmd.accept     = (state_ff == S_IDLE) && req_tvalid;
      cmd.mul        = (state_ff == S_MUL);
      cmd.mem_access = (state_ff == S_MUL) && (step_ff == 2'd0);
      cmd.add        = (state_ff == S_ADD);
      cmd.load_rsp   = (state_ff == S_DONE) && slot_free;
   end

   // State, step counter and result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces the one taken in the same cycle
         if (cmd.load_rsp)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  step_ff  <= 2'd0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               state_ff <= S_ADD;
            end
            S_ADD: begin
               if (status.last_step) begin
                  state_ff <= S_DONE;
               end else begin
                  step_ff  <= step_ff + 2'd1;
                  state_ff <= S_MUL;
               end
            end
            S_DONE: begin
               if (slot_free)
                  state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Result only goes into a free output slot
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> slot_free)
      else $error("result loaded over an unsent item");

   // A loaded result is offered next cycle and the block is idle again
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("loaded result not offered");

   // Every time advance follows its multiply stage
   a_add_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD) |-> ($past(state_ff) == S_MUL))
      else $error("time advance without multiply stage");

   // RAM is touched only on the first step
   a_mem_once: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_access |-> (cmd.mul && step_ff == 2'd0))
      else $error("RAM access outside first step");

endmodule

>>> rtl/core/cbpa_datapath.sv
// Datapath: item registers, RAM, contention timing unit, config registers.
// Depends on cbpa_pkg; sequenced by cbpa_ctrl.
module cbpa_datapath
   import cbpa_pkg::*;
#(
   parameter int CONTENTION_START = 14335,
   parameter int LINE_TSTATES     = 224,
   parameter int CONTENDED_LINES  = 192,
   parameter int RAM_BYTES        = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [1:0]          req_kind,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [DATA_W-1:0]   req_data,
   input  logic [TSTATE_W-1:0] req_tstate,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_data,
   output logic [TSTATE_W-1:0] rsp_tstate_after,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [2:0]          rsp_border
);

   localparam int RAM_AW      = $clog2(RAM_BYTES);
   localparam int SPAN        = CONTENDED_LINES * LINE_TSTATES;
   localparam int RECIP_SHIFT = TIME_W;
   localparam int RECIP       = (1 << RECIP_SHIFT) / LINE_TSTATES;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = TSTATE_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [TIME_W-1:0]  START_V = TIME_W'(CONTENTION_START);
   localparam logic [TIME_W-1:0]  SPAN_V  = TIME_W'(SPAN);
   localparam logic [TIME_W-1:0]  LINE_V  = TIME_W'(LINE_TSTATES);
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

   // Item registers
   kind_type          kind_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] data_ff;
   logic [TIME_W-1:0] time_ff;

   // Config and architectural state
   logic [63:0]       key_rows_ff;
   logic [7:0]        joystick_ff;
   logic              rom_wr_ff;
   logic [2:0]        border_ff;

   // RAM and its registered read
   logic [7:0]        mem_q [RAM_BYTES];
   logic [7:0]        ram_rd_ff;

   // Timing pipeline registers
   logic [TIME_W-1:0] offset_ff;
   logic              in_window_ff;
   logic [PROD_W-1:0] prod_ff;

   logic              even_port;
   logic              contended;
   logic [3:0]        step_len;
   logic [TIME_W-1:0] offset_in;
   logic              in_window_in;
   logic [QUOT_W-1:0] quot;
   logic [TIME_W-1:0] line_base;
   logic [TIME_W-1:0] pos_raw;
   logic [TIME_W-1:0] pos;
   logic [2:0]        delay;
   logic [TIME_W-1:0] time_in;
   logic [7:0]        port_rd;
   logic [7:0]        read_in;
   logic [2:0]        border_in;
   logic              mem_write;

   assign even_port = !addr_ff[0];
   assign contended = (addr_ff[ADDR_W-1 -: 2] == CONT_BANK);

   // Step length and last-step flag
   always_comb begin
      step_len         = LEN_IO_SHORT;
      status.last_step = 1'b0;
      if (kind_ff == KIND_MEM_RD || kind_ff == KIND_MEM_WR) begin
         step_len         = LEN_MEM;
         status.last_step = 1'b1;
      end else if (even_port) begin
         step_len         = (cmd.step_idx == 2'd0) ? LEN_IO_SHORT : LEN_IO_EVEN;
         status.last_step = (cmd.step_idx == 2'd1);
      end else begin
         status.last_step = (cmd.step_idx == 2'd3);
      end
   end

   // First half of a step: window check and line reciprocal product
   assign offset_in    = time_ff - START_V;
   assign in_window_in = (time_ff >= START_V) && (offset_in < SPAN_V);

   // Second half: remainder within the line, one correction, delay lookup, time advance
   always_comb begin
      quot      = prod_ff[PROD_W-1 -: QUOT_W];
      line_base = TIME_W'(quot) * LINE_V;
      pos_raw   = offset_ff - line_base;
      pos       = (pos_raw >= LINE_V) ? pos_raw - LINE_V : pos_raw;
      delay     = 3'd0;
      if (contended && in_window_ff && pos < TIME_W'(PATTERN_SPAN))
         delay = delay_of(pos[2:0]);
      time_in   = time_ff + TIME_W'(delay) + TIME_W'(step_len);
   end

   // Port read value: keyboard rows or joystick
   always_comb begin
      port_rd = 8'h00;
      if (even_port) begin
         port_rd = IDLE_BUS;
         for (int i = 0; i < 8; i++) begin
            if (!addr_ff[8 + i])
               port_rd = port_rd & ~key_rows_ff[8*i +: 8];
         end
      end else if (addr_ff[7:0] == JOY_PORT) begin
         port_rd = joystick_ff;
      end
   end

   always_comb begin
      unique case (kind_ff)
         KIND_MEM_RD:  read_in = ram_rd_ff;
         KIND_PORT_IN: read_in = port_rd;
         default:      read_in = 8'h00;
      endcase
      border_in = border_ff;
      if (kind_ff == KIND_PORT_OUT && even_port)
         border_in = data_ff[2:0];
   end

   assign mem_write = cmd.mem_access && (kind_ff == KIND_MEM_WR)
                      && (rom_wr_ff || addr_ff >= ROM_TOP);

   // RAM
   always_ff @(posedge clock) begin
      if (mem_write)
         mem_q[addr_ff[RAM_AW-1:0]] <= data_ff;
      if (cmd.mem_access)
         ram_rd_ff <= mem_q[addr_ff[RAM_AW-1:0]];
   end

   // Item and timing pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= kind_type'(req_kind);
         addr_ff <= req_address;
         data_ff <= req_data;
         time_ff <= TIME_W'(req_tstate);
      end
      if (cmd.mul) begin
         offset_ff    <= offset_in;
         in_window_ff <= in_window_in;
         prod_ff      <= PROD_W'(offset_in[TSTATE_W-1:0]) * PROD_W'(RECIP_V);
      end
      if (cmd.add)
         time_ff <= time_in;
      if (cmd.load_rsp) begin
         rsp_tstate_after <= (time_ff > TIME_W'(TSTATE_MAX)) ? TSTATE_MAX
                                                             : time_ff[TSTATE_W-1:0];
         rsp_read_data    <= read_in;
         rsp_border       <= border_in;
      end
   end

   // Config registers and border colour
   always_ff @(posedge clock) begin
      if (reset) begin
         key_rows_ff <= 64'd0;
         joystick_ff <= 8'd0;
         rom_wr_ff   <= 1'b1;
         border_ff   <= 3'd7;
      end else begin
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_KEY_ROWS:  key_rows_ff <= csr_data;
               CSR_JOYSTICK:  joystick_ff <= csr_data[7:0];
               CSR_ROM_WRITE: rom_wr_ff   <= csr_data[0];
               default:       ;
            endcase
         end
         if (cmd.load_rsp)
            border_ff <= border_in;
      end
   end

   // Corrected remainder always lies inside the line
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.add && in_window_ff) |-> (pos < LINE_V))
      else $error("line position out of range");

   // Time never moves backwards over a step
   a_time_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.add |=> (time_ff > $past(time_ff)))
      else $error("time did not advance");

   // Uncontended steps add exactly the base length
   a_no_delay: assert property (@(posedge clock) disable iff (reset)
      (cmd.add && !contended) |-> (delay == 3'd0))
      else $error("delay on uncontended address");

endmodule

>>> rtl/core/contended_bus_and_port_access.sv
// Each timing step runs a multiply state, then an add state, in the shared
// contention unit (reciprocal multiply, then remainder and add); the number of steps
// depends on the access kind and, for a port, on the port address.
// A new item is taken only once the previous result is loaded; a waiting result
// only holds the next one back when its own result is ready to load.
// Reset clears control, key rows and joystick, enables ROM writes and sets border 7; RAM is not cleared.
module contended_bus_and_port_access
   import cbpa_pkg::*;
#(
   parameter int CONTENTION_START = 14335,
   parameter int LINE_TSTATES     = 224,
   parameter int CONTENDED_LINES  = 192,
   parameter int RAM_BYTES        = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // address [15:0], data [23:16], tstate [40:24], zero fill above
   input  logic [47:0] req_tdata,
   // kind [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tstate_after [16:0], read_data [24:17], border [27:25], zero fill above
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   cmd_type             cmd;
   status_type          status;
   logic [TSTATE_W-1:0] tstate_after;
   logic [DATA_W-1:0]   read_data;
   logic [2:0]          border;

   // Config writes are always taken
   assign csr_ready = 1'b1;

   assign rsp_tdata = {4'd0, border, read_data, tstate_after};

   cbpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cbpa_datapath #(
      .CONTENTION_START (CONTENTION_START),
      .LINE_TSTATES     (LINE_TSTATES),
      .CONTENDED_LINES  (CONTENDED_LINES),
      .RAM_BYTES        (RAM_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_tuser),
      .req_address      (req_tdata[15:0]),
      .req_data         (req_tdata[23:16]),
      .req_tstate       (req_tdata[40:24]),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_tstate_after (tstate_after),
      .rsp_read_data    (read_data),
      .rsp_border       (border)
   );

endmodule

>>> bench/contended_bus_and_port_access_test.sv
`timescale 1ns / 100ps
// Self-checking bench for contended_bus_and_port_access: directed table, then random accesses.
// Depends on cbpa_pkg and the block's RTL; predicts timing, RAM, port reads and border itself.
module contended_bus_and_port_access_test;
   import cbpa_pkg::*;

   localparam int CONTENTION_START = 14335;
   localparam int LINE_TSTATES     = 224;
   localparam int CONTENDED_LINES  = 192;
   localparam int RAM_BYTES        = 65536;
   localparam int WINDOW_SPAN      = CONTENDED_LINES * LINE_TSTATES;
   localparam int unsigned TIME_LIMIT = 131071;
   localparam int PHASE_ITEMS      = 250;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [16:0] tstate_after;
      logic [7:0]  read_data;
      logic [2:0]  border;
   } access_result_type;

   typedef struct packed {
      kind_type          kind;
      logic [15:0]       addr;
      logic [7:0]        data;
      logic [16:0]       tstate;
      logic              typed;
      access_result_type result;
   } access_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   // predictor state
   logic [7:0]  mem_image [0:RAM_BYTES-1];
   bit          mem_written [0:RAM_BYTES-1];
   logic [15:0] written_addrs [$];
   logic [2:0]  model_border;
   logic [63:0] model_key_rows;
   logic [7:0]  model_joystick;
   logic        model_rom_writable;

   access_result_type expected_results [$];
   int unsigned       mismatch_count = 0;
   bit                idle_on = 1'b1;

   // directed table: typed results only where obvious from reset state
   access_row_type directed_rows [0:21] = '{
      '{KIND_PORT_IN,  16'h00fe, 8'h00, 17'd0,      1'b1, '{17'd4, 8'hff, 3'd7}},
      '{KIND_PORT_IN,  16'h001f, 8'h00, 17'd0,      1'b1, '{17'd4, 8'h00, 3'd7}},
      '{KIND_PORT_OUT, 16'h00fe, 8'h00, 17'd10,     1'b1, '{17'd14, 8'h00, 3'd0}},
      '{KIND_PORT_OUT, 16'h00fe, 8'hff, 17'd20,     1'b1, '{17'd24, 8'h00, 3'd7}},
      '{KIND_PORT_OUT, 16'h00ff, 8'h05, 17'd30,     1'b1, '{17'd34, 8'h00, 3'd7}},
      '{KIND_MEM_WR,   16'h0000, 8'hff, 17'd0,      1'b1, '{17'd3, 8'h00, 3'd7}},
      '{KIND_MEM_RD,   16'h0000, 8'h00, 17'd0,      1'b1, '{17'd3, 8'hff, 3'd7}},
      '{KIND_MEM_WR,   16'hffff, 8'h00, 17'd131071, 1'b1, '{17'd131071, 8'h00, 3'd7}},
      '{KIND_MEM_RD,   16'hffff, 8'hff, 17'd131070, 1'b1, '{17'd131071, 8'h00, 3'd7}},
      '{KIND_MEM_WR,   16'h4000, 8'ha5, 17'd14335,  1'b1, '{17'd14344, 8'h00, 3'd7}},
      '{KIND_MEM_RD,   16'h4000, 8'h00, 17'd14336,  1'b1, '{17'd14344, 8'ha5, 3'd7}},
      '{KIND_MEM_WR,   16'h7fff, 8'h5a, 17'd14462,  1'b0, '0},
      '{KIND_MEM_RD,   16'h7fff, 8'h00, 17'd14463,  1'b0, '0},
      '{KIND_MEM_WR,   16'h8000, 8'h3c, 17'd14335,  1'b0, '0},
      '{KIND_MEM_RD,   16'h4000, 8'h00, 17'd14334,  1'b0, '0},
      '{KIND_MEM_RD,   16'h4000, 8'h00, 17'd57119,  1'b0, '0},
      '{KIND_MEM_RD,   16'h4000, 8'h00, 17'd57343,  1'b0, '0},
      '{KIND_MEM_RD,   16'h4000, 8'h00, 17'd57344,  1'b0, '0},
      '{KIND_PORT_IN,  16'h40fe, 8'h00, 17'd14335,  1'b0, '0},
      '{KIND_PORT_IN,  16'h401f, 8'h00, 17'd14336,  1'b0, '0},
      '{KIND_PORT_OUT, 16'h7ffe, 8'h03, 17'd14340,  1'b0, '0},
      '{KIND_PORT_IN,  16'h3ffe, 8'h00, 17'd0,      1'b0, '0}
   };

   contended_bus_and_port_access #(
      .CONTENTION_START(CONTENTION_START),
      .LINE_TSTATES    (LINE_TSTATES),
      .CONTENDED_LINES (CONTENDED_LINES),
      .RAM_BYTES       (RAM_BYTES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one timing step, with display contention when the address is in the contended bank
   function automatic int unsigned advance(input int unsigned t, input logic [15:0] addr,
                                           input int unsigned len);
      int unsigned pos;
      int unsigned wait_states;
      wait_states = 0;
      if (addr[15:14] == CONT_BANK && t >= CONTENTION_START
          && t - CONTENTION_START < WINDOW_SPAN) begin
         pos = (t - CONTENTION_START) % LINE_TSTATES;
         if (pos < 128) begin
            case (pos % 8)
               0: wait_states = 6;
               1: wait_states = 5;
               2: wait_states = 4;
               3: wait_states = 3;
               4: wait_states = 2;
               5: wait_states = 1;
               default: wait_states = 0;
            endcase
         end
      end
      return t + wait_states + len;
   endfunction

   // timing, read byte and border after one access; updates RAM and border
   function automatic access_result_type predict_access(input kind_type kind,
         input logic [15:0] addr, input logic [7:0] data, input logic [16:0] tstate);
      access_result_type res;
      int unsigned       t;
      logic [7:0]        rd;
      int                i;
      t = tstate;
      rd = 8'h00;
      if (kind == KIND_MEM_RD || kind == KIND_MEM_WR) begin
         t = advance(t, addr, 3);
         if (kind == KIND_MEM_RD) begin
            rd = mem_image[addr];
         end else if (model_rom_writable || addr >= ROM_TOP) begin
            mem_image[addr] = data;
            if (!mem_written[addr]) begin
               mem_written[addr] = 1'b1;
               written_addrs.push_back(addr);
            end
         end
      end else begin
         t = advance(t, addr, 1);
         if (!addr[0]) begin
            t = advance(t, addr, 3);
         end else begin
            t = advance(t, addr, 1);
            t = advance(t, addr, 1);
            t = advance(t, addr, 1);
         end
         if (kind == KIND_PORT_IN) begin
            if (!addr[0]) begin
               // keyboard: each selected row (high address bit low) pulls its keys low
               rd = IDLE_BUS;
               for (i = 0; i < 8; i++) begin
                  if (!addr[8+i])
                     rd = rd & ~model_key_rows[8*i +: 8];
               end
            end else if (addr[7:0] == JOY_PORT) begin
               rd = model_joystick;
            end
         end else if (!addr[0]) begin
            model_border = data[2:0];
         end
      end
      if (t > TIME_LIMIT)
         t = TIME_LIMIT;
      res.tstate_after = t[16:0];
      res.read_data    = rd;
      res.border       = model_border;
      return res;
   endfunction

   // offer one item, called and returning at a falling edge
   task automatic send_access(input kind_type kind, input logic [15:0] addr,
                              input logic [7:0] data, input logic [16:0] tstate);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, tstate, data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_KEY_ROWS:  model_key_rows = value;
         CSR_JOYSTICK:  model_joystick = value[7:0];
         CSR_ROM_WRITE: model_rom_writable = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // wait until every predicted item has come back, then let the block settle
   task automatic drain_results;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic random_access;
      kind_type          kind;
      logic [15:0]       addr;
      logic [7:0]        data;
      logic [16:0]       tstate;
      int unsigned       sel;
      access_result_type exp;
      kind = kind_type'($urandom_range(0, 3));
      if (kind == KIND_MEM_RD && written_addrs.size() == 0)
         kind = KIND_MEM_WR;
      data = 8'($urandom);
      sel = $urandom_range(0, 7);
      // reads only ever touch bytes already written
      if (kind == KIND_MEM_RD) begin
         addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      end else if (kind == KIND_MEM_WR) begin
         case (sel)
            0, 1, 2: addr = {CONT_BANK, 14'($urandom)};
            3, 4:    addr = {2'b00, 14'($urandom)};
            default: addr = 16'($urandom);
         endcase
      end else begin
         case (sel)
            0, 1:    addr = {8'($urandom), JOY_PORT};
            2, 3:    addr = {8'($urandom), 7'($urandom), 1'b0};
            4:       addr = {CONT_BANK, 14'($urandom)};
            default: addr = 16'($urandom);
         endcase
      end
      sel = $urandom_range(0, 7);
      case (sel)
         0, 1, 2, 3: tstate = 17'(CONTENTION_START + $urandom_range(0, WINDOW_SPAN + 255));
         4:          tstate = 17'(CONTENTION_START - 8 + $urandom_range(0, 16));
         5:          tstate = 17'(TIME_LIMIT - $urandom_range(0, 24));
         6:          tstate = 17'($urandom_range(0, TIME_LIMIT));
         default:    tstate = 17'($urandom_range(0, CONTENTION_START - 1));
      endcase
      exp = predict_access(kind, addr, data, tstate);
      expected_results.push_back(exp);
      send_access(kind, addr, data, tstate);
   endtask

   // result side back-pressure in bursts
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
      end
   end

   // compare every accepted result item with the oldest prediction
   always @(posedge clock) begin : result_check
      access_result_type got;
      access_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[16:0], rsp_tdata[24:17], rsp_tdata[27:25]};
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result t=%0d rd=%02h border=%0d", $time,
                        got.tstate_after, got.read_data, got.border);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: expected t=%0d rd=%02h bd=%0d, got t=%0d rd=%02h bd=%0d",
                           $time, want.tstate_after, want.read_data, want.border,
                           got.tstate_after, got.read_data, got.border);
            end
         end
      end
   end

   // hard stop should the block hang
   initial begin
      #2000000;
      $display("contended_bus_and_port_access test failed");
      $finish;
   end

   initial begin : stimulus
      int                row;
      int                phase;
      logic [63:0]       keys;
      logic [7:0]        joy;
      logic              rom;
      access_result_type exp;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      model_border       = 3'd7;
      model_key_rows     = '0;
      model_joystick     = '0;
      model_rom_writable = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items with reset configuration
      for (row = 0; row < $size(directed_rows); row++) begin
         exp = predict_access(directed_rows[row].kind, directed_rows[row].addr,
                              directed_rows[row].data, directed_rows[row].tstate);
         if (directed_rows[row].typed)
            exp = directed_rows[row].result;
         expected_results.push_back(exp);
         send_access(directed_rows[row].kind, directed_rows[row].addr,
                     directed_rows[row].data, directed_rows[row].tstate);
      end

      // random phases, each under its own register setting; last one without idling
      for (phase = 0; phase < 5; phase++) begin
         req_tvalid <= 1'b0;
         drain_results();
         keys = {$urandom, $urandom};
         joy  = 8'($urandom);
         rom  = 1'b1;
         case (phase)
            0: begin
               keys = '1;
               joy  = 8'hff;
               rom  = 1'b0;
            end
            2: begin
               keys = '0;
               joy  = 8'h00;
               rom  = 1'b0;
            end
            3: rom = 1'($urandom_range(0, 1));
            default: ;
         endcase
         write_register(CSR_KEY_ROWS, keys);
         write_register(CSR_JOYSTICK, {56'd0, joy});
         write_register(CSR_ROM_WRITE, {63'd0, rom});
         // out-of-range index must leave everything alone
         write_register(CSR_UNUSED, {$urandom, $urandom});
         if (phase == 4)
            idle_on = 1'b0;
         repeat (PHASE_ITEMS) random_access();
      end
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("contended_bus_and_port_access test passed");
      else
         $display("contended_bus_and_port_access test failed");
      $finish;
   end

endmodule
